[hdl/hcfr_pkg.sv]
`default_nettype none
package hcfr_pkg;

    localparam int HDR_LEN = 4;

    // configuration register indexes
    localparam logic [2:0] REG_HDR_0  = 3'd0;
    localparam logic [2:0] REG_HDR_1  = 3'd1;
    localparam logic [2:0] REG_HDR_2  = 3'd2;
    localparam logic [2:0] REG_HDR_3  = 3'd3;
    localparam logic [2:0] REG_GAIN   = 3'd4;
    localparam logic [2:0] REG_OFFSET = 3'd5;

    localparam logic [7:0]  RST_HDR_0  = 8'hA5;
    localparam logic [7:0]  RST_HDR_1  = 8'h5A;
    localparam logic [7:0]  RST_HDR_2  = 8'h11;
    localparam logic [7:0]  RST_HDR_3  = 8'hF5;
    localparam logic [7:0]  RST_GAIN   = 8'd161;
    localparam logic [15:0] RST_OFFSET = 16'd1000;

    // x / 1000 == (x * DIV_RECIP) >> DIV_SHIFT for every x below 2**24
    localparam int          DIV_SHIFT = 34;
    localparam logic [24:0] DIV_RECIP = 25'd17179870;

    typedef struct packed {
        logic        frame_status;
        logic [15:0] command_word;
        logic [15:0] cent_mag;
        logic        cent_neg;
    } frame_res_t;

endpackage
`default_nettype wire

[hdl/hcfr_sync.sv]
`default_nettype none
module hcfr_sync
    import hcfr_pkg::*;
#(
    parameter int FRAME_LENGTH = 15
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_rx_byte,
    input  wire logic [HDR_LEN-1:0][7:0]    header_bytes,
    input  wire logic [15:0]                center_offset,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output frame_res_t                      res
);

    localparam int IDX_W = $clog2(FRAME_LENGTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LENGTH - 1);
    localparam logic [IDX_W-1:0] HI_IDX   = IDX_W'(8);
    localparam logic [IDX_W-1:0] LO_IDX   = IDX_W'(9);
    localparam int MATCH_W = $clog2(HDR_LEN);
    localparam logic [MATCH_W-1:0] LAST_MATCH = MATCH_W'(HDR_LEN - 1);

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic               hunt_reg,  hunt_next;
    logic [MATCH_W-1:0] match_reg, match_next;
    logic [IDX_W-1:0]   idx_reg,   idx_next;
    logic [7:0]         sum_reg,   sum_next;
    logic [7:0]         word_hi_reg;
    logic [7:0]         word_lo_reg;

    logic        emit;
    logic        step;
    logic [7:0]  check;
    logic [15:0] word;
    logic [16:0] diff;

    assign emit    = in_vld_reg && !hunt_reg && (idx_reg == LAST_IDX);
    assign step    = in_vld_reg && (!emit || res_ready);
    assign s_ready = !in_vld_reg || step;

    assign check = sum_reg + header_bytes[2] + header_bytes[3];
    assign word  = {word_hi_reg, word_lo_reg};
    assign diff  = {1'b0, word} - {1'b0, center_offset};

    always_comb begin
        res_valid        = emit;
        res.frame_status = (in_byte_reg != check);
        res.command_word = word;
        res.cent_neg     = diff[16];
        res.cent_mag     = diff[16] ? (16'd0 - diff[15:0]) : diff[15:0];
        if (res.frame_status) begin
            res.command_word = 16'd0;
            res.cent_neg     = 1'b0;
            res.cent_mag     = 16'd0;
        end
    end

    always_comb begin
        hunt_next  = hunt_reg;
        match_next = match_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        if (hunt_reg) begin
            if (in_byte_reg == header_bytes[match_reg]) begin
                if (match_reg == LAST_MATCH) begin
                    hunt_next  = 1'b0;
                    match_next = '0;
                    idx_next   = '0;
                    sum_next   = 8'd0;
                end else begin
                    match_next = match_reg + MATCH_W'(1);
                end
            end else begin
                // failed byte is dropped, not retried as a first header byte
                match_next = '0;
            end
        end else if (idx_reg == LAST_IDX) begin
            hunt_next  = 1'b1;
            match_next = '0;
            idx_next   = '0;
            sum_next   = 8'd0;
        end else begin
            sum_next = sum_reg + in_byte_reg;
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            hunt_reg   <= 1'b1;
            match_reg  <= '0;
            idx_reg    <= '0;
            sum_reg    <= 8'd0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (step) begin
                hunt_reg  <= hunt_next;
                match_reg <= match_next;
                idx_reg   <= idx_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step && !hunt_reg) begin
            if (idx_reg == HI_IDX) begin
                word_hi_reg <= in_byte_reg;
            end
            if (idx_reg == LO_IDX) begin
                word_lo_reg <= in_byte_reg;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/hcfr_steer.sv]
`default_nettype none
module hcfr_steer
    import hcfr_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire frame_res_t    in_res,
    input  wire logic [7:0]    steering_gain,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_frame_status,
    output logic [15:0]        m_command_word,
    output logic signed [15:0] m_steering_value
);

    logic        b_vld_reg;
    frame_res_t  b_res_reg;

    logic        c_vld_reg;
    logic [23:0] c_prod_reg;
    logic        c_status_reg;
    logic [15:0] c_word_reg;
    logic        c_neg_reg;

    logic               out_vld_reg;
    logic               out_status_reg;
    logic [15:0]        out_word_reg;
    logic signed [15:0] out_steer_reg;

    logic        out_go;
    logic        c_free;
    logic [48:0] q_full;
    logic [14:0] quot;
    logic [15:0] steer;

    assign out_go   = !out_vld_reg || m_ready;
    assign c_free   = !c_vld_reg || out_go;
    assign in_ready = !b_vld_reg || c_free;

    // magnitude divided by 1000 through the reciprocal, sign put back after
    assign q_full = 49'(c_prod_reg) * 49'(DIV_RECIP);
    assign quot   = q_full[DIV_SHIFT +: 15];
    assign steer  = c_neg_reg ? (16'd0 - {1'b0, quot}) : {1'b0, quot};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                b_vld_reg <= in_valid;
            end
            if (c_free) begin
                c_vld_reg <= b_vld_reg;
            end
            if (out_go) begin
                out_vld_reg <= c_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            b_res_reg <= in_res;
        end
        if (c_free && b_vld_reg) begin
            c_prod_reg   <= 24'(steering_gain) * 24'(b_res_reg.cent_mag);
            c_status_reg <= b_res_reg.frame_status;
            c_word_reg   <= b_res_reg.command_word;
            c_neg_reg    <= b_res_reg.cent_neg;
        end
        if (out_go && c_vld_reg) begin
            out_status_reg <= c_status_reg;
            out_word_reg   <= c_word_reg;
            out_steer_reg  <= steer;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_frame_status   = out_status_reg;
    assign m_command_word   = out_word_reg;
    assign m_steering_value = out_steer_reg;

endmodule
`default_nettype wire

[hdl/header_checksum_frame_receiver_top.sv]
// Frame receiver: takes one received byte per word on the s_ channel, hunts for the
// four configured header bytes, then collects FRAME_LENGTH frame bytes whose last one
// must equal the 8-bit sum of the others plus header bytes two and three. Each completed
// frame gives one word on the m_ channel: the checksum status and, when good, the
// big-endian word at frame bytes 8 and 9 and gain * (word - offset) / 1000 rounded toward
// zero (both zero on a bad checksum). A byte is taken every clock cycle unless m_ready stalls
// the last frame byte. A result passes the input byte register, the centring stage, the gain
// multiplier and the reciprocal multiplier feeding the output register. Configuration must
// be written through cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not check.
`default_nettype none
module header_checksum_frame_receiver_top
    import hcfr_pkg::*;
#(
    parameter int FRAME_LENGTH = 15
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_frame_status,
    output logic [15:0]        m_command_word,
    output logic signed [15:0] m_steering_value
);

    logic [HDR_LEN-1:0][7:0] hdr_reg;
    logic [7:0]              gain_reg;
    logic [15:0]             offset_reg;

    logic       res_valid;
    logic       res_ready;
    frame_res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg[0] <= RST_HDR_0;
            hdr_reg[1] <= RST_HDR_1;
            hdr_reg[2] <= RST_HDR_2;
            hdr_reg[3] <= RST_HDR_3;
            gain_reg   <= RST_GAIN;
            offset_reg <= RST_OFFSET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HDR_0:  hdr_reg[0] <= cfg_wdata[7:0];
                REG_HDR_1:  hdr_reg[1] <= cfg_wdata[7:0];
                REG_HDR_2:  hdr_reg[2] <= cfg_wdata[7:0];
                REG_HDR_3:  hdr_reg[3] <= cfg_wdata[7:0];
                REG_GAIN:   gain_reg   <= cfg_wdata[7:0];
                REG_OFFSET: offset_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    hcfr_sync #(
        .FRAME_LENGTH(FRAME_LENGTH)
    ) u_sync (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .header_bytes (hdr_reg),
        .center_offset(offset_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    hcfr_steer u_steer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (res_valid),
        .in_ready        (res_ready),
        .in_res          (res),
        .steering_gain   (gain_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_status  (m_frame_status),
        .m_command_word  (m_command_word),
        .m_steering_value(m_steering_value)
    );

endmodule
`default_nettype wire
